FILE: rtl/tmp_pkg.sv
package tmp_pkg;

   // fixed widths of the fields
   localparam int unsigned POS_W        = 32;
   localparam int unsigned INC_W        = 31;
   localparam int unsigned FLIM_W       = 15;
   localparam int unsigned WIDE_W       = 34;
   localparam int unsigned FORCE_SLOTS  = 6;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 32;

   // parameter defaults
   localparam int unsigned MAX_STEPS_DEFAULT  = 65535;
   localparam int unsigned FORCE_AXES_DEFAULT = 6;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAVEL_DISTANCE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_INCREMENT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_LIMIT      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORCE_LIMIT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORCE_CHECK_ON  = 3'd4;

   // configuration seen by the datapath
   typedef struct packed {
      logic signed [POS_W-1:0] travel_distance;
      logic [INC_W-1:0]        step_increment;
      logic [INC_W-1:0]        step_limit;
      logic [FLIM_W-1:0]       force_limit;
      logic                    force_check_on;
   } cfg_type;

   // one registered input beat
   typedef struct packed {
      logic                                    func;
      logic signed [POS_W-1:0]                 start_pos;
      logic                                    move_negative;
      logic [FORCE_SLOTS-1:0][POS_W-1:0]       forces;
   } item_type;

   // one result beat
   typedef struct packed {
      logic signed [POS_W-1:0] set_point;
      logic                    point_valid;
      logic                    move_done;
      logic                    force_fault;
      logic                    step_overrun;
   } result_type;

   // sign and zero extension to the wide arithmetic width
   function automatic logic signed [WIDE_W-1:0] sext(input logic signed [POS_W-1:0] v);
      return {{(WIDE_W-POS_W){v[POS_W-1]}}, v};
   endfunction

   function automatic logic signed [WIDE_W-1:0] zext(input logic [INC_W-1:0] v);
      return {{(WIDE_W-INC_W){1'b0}}, v};
   endfunction

   // clamp a wide value into the signed 32-bit range
   function automatic logic signed [POS_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if ((&v[WIDE_W-1:POS_W-1]) || !(|v[WIDE_W-1:POS_W-1])) begin
         r = v[POS_W-1:0];
      end else if (v[WIDE_W-1]) begin
         r = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(POS_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

FILE: rtl/tmp_csr.sv
module tmp_csr
   import tmp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TRAVEL_DISTANCE: cfg_in.travel_distance = csr_data;
            CSR_STEP_INCREMENT:  cfg_in.step_increment  = csr_data[INC_W-1:0];
            CSR_STEP_LIMIT:      cfg_in.step_limit      = csr_data[INC_W-1:0];
            CSR_FORCE_LIMIT:     cfg_in.force_limit     = csr_data[FLIM_W-1:0];
            CSR_FORCE_CHECK_ON:  cfg_in.force_check_on  = csr_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.travel_distance <= '0;
         cfg_ff.step_increment  <= '0;
         cfg_ff.step_limit      <= '0;
         cfg_ff.force_limit     <= '1;
         cfg_ff.force_check_on  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/tmp_force_check.sv
module tmp_force_check
   import tmp_pkg::*;
#(
   parameter int unsigned FORCE_AXES = FORCE_AXES_DEFAULT
)
(
   input  logic [FORCE_SLOTS-1:0][POS_W-1:0] forces,
   input  logic [FLIM_W-1:0]                 force_limit,
   input  logic                              force_check_on,
   output logic                              force_bad
);

   logic [POS_W-1:0]       lim;
   logic [FORCE_SLOTS-1:0] over;

   // limit in Q16.16
   assign lim = {1'b0, force_limit, 16'b0};

   // magnitude of each checked sample against the limit
   always_comb begin
      for (int i = 0; i < FORCE_SLOTS; i++) begin
         logic [POS_W-1:0] mag;
         mag = forces[i][POS_W-1] ? (~forces[i] + 1'b1) : forces[i];
         over[i] = (i < FORCE_AXES) && (mag > lim);
      end
   end

   assign force_bad = force_check_on && (|over);

endmodule

FILE: rtl/tmp_profile_core.sv
module tmp_profile_core
   import tmp_pkg::*;
#(
   parameter int unsigned MAX_STEPS = MAX_STEPS_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  cfg_type    cfg,
   input  logic       force_bad,
   output result_type result
);

   localparam int unsigned COUNT_W = $clog2(MAX_STEPS + 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ACCEL,
      PH_CRUISE,
      PH_DECEL
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic signed [POS_W-1:0] step_ff, step_in;
   logic signed [POS_W-1:0] origin_ff, origin_in;
   logic signed [POS_W-1:0] target_ff, target_in;
   logic signed [POS_W-1:0] ramp_ff, ramp_in;
   logic                    down_ff, down_in;
   logic [COUNT_W-1:0]      count_ff, count_in;

   logic signed [WIDE_W-1:0] inc_w, lim_w, dist_w, start_w;
   logic                     down_s;
   logic signed [POS_W-1:0]  step_s, step_a, ramp_a, ramp_c, step_c, step_d, step_n;
   logic signed [WIDE_W-1:0] ahead;
   logic                     reached, slow, stop, have;

   assign inc_w   = zext(cfg.step_increment);
   assign lim_w   = zext(cfg.step_limit);
   assign start_w = sext(item.start_pos);

   // start of a move
   assign dist_w = item.move_negative ? -sext(cfg.travel_distance) : sext(cfg.travel_distance);
   assign down_s = dist_w[WIDE_W-1];
   assign step_s = down_s ? sat32(-inc_w) : sat32(inc_w);

   // acceleration step and its end test
   assign step_a  = sat32(down_ff ? sext(step_ff) - inc_w : sext(step_ff) + inc_w);
   assign reached = down_ff ? (-sext(step_a) >= lim_w) : (sext(step_a) >= lim_w);
   assign ramp_a  = sat32(sext(pos_ff) - sext(origin_ff));

   // cruise test, with the ramp just taken when acceleration ends this tick
   assign ramp_c = (phase_ff == PH_ACCEL) ? ramp_a : ramp_ff;
   assign ahead  = sext(pos_ff) + sext(ramp_c);
   assign slow   = down_ff ? (ahead <= sext(target_ff)) : (ahead >= sext(target_ff));

   // deceleration step and its stop test
   assign step_c = (phase_ff == PH_ACCEL) ? step_a : step_ff;
   assign step_d = sat32(down_ff ? sext(step_c) + inc_w : sext(step_c) - inc_w);
   assign stop   = down_ff ? (step_d > 0) : (step_d < 0);

   // next state and result
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      step_in   = step_ff;
      origin_in = origin_ff;
      target_in = target_ff;
      ramp_in   = ramp_ff;
      down_in   = down_ff;
      count_in  = count_ff;
      have      = 1'b0;
      step_n    = step_ff;

      result.set_point    = pos_ff;
      result.point_valid  = 1'b0;
      result.move_done    = 1'b1;
      result.force_fault  = 1'b0;
      result.step_overrun = 1'b0;

      if (force_bad) begin
         phase_in           = PH_IDLE;
         result.force_fault = 1'b1;
      end else if (!item.func) begin
         origin_in          = item.start_pos;
         down_in            = down_s;
         target_in          = sat32(start_w + dist_w);
         step_in            = step_s;
         pos_in             = sat32(start_w + sext(step_s));
         ramp_in            = '0;
         phase_in           = PH_ACCEL;
         count_in           = COUNT_W'(1);
         result.set_point   = pos_in;
         result.point_valid = 1'b1;
         result.move_done   = 1'b0;
      end else if (phase_ff != PH_IDLE) begin
         if (phase_ff == PH_ACCEL && !reached) begin
            have   = 1'b1;
            step_n = step_a;
         end else if (phase_ff != PH_DECEL && !slow) begin
            have     = 1'b1;
            step_n   = step_c;
            ramp_in  = ramp_c;
            phase_in = PH_CRUISE;
         end else begin
            step_n   = step_d;
            ramp_in  = ramp_c;
            if (stop) begin
               phase_in = PH_IDLE;
            end else begin
               have     = 1'b1;
               phase_in = PH_DECEL;
            end
         end
         step_in = step_n;

         if (have) begin
            if (count_ff >= COUNT_W'(MAX_STEPS)) begin
               phase_in            = PH_IDLE;
               result.step_overrun = 1'b1;
            end else begin
               count_in           = count_ff + 1'b1;
               pos_in             = sat32(sext(pos_ff) + sext(step_n));
               result.set_point   = pos_in;
               result.point_valid = 1'b1;
               result.move_done   = 1'b0;
            end
         end
      end
   end

   // profile state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         step_ff   <= '0;
         origin_ff <= '0;
         target_ff <= '0;
         ramp_ff   <= '0;
         down_ff   <= 1'b0;
         count_ff  <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         step_ff   <= step_in;
         origin_ff <= origin_in;
         target_ff <= target_in;
         ramp_ff   <= ramp_in;
         down_ff   <= down_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/trapezoid_motion_profile_unit.sv
// throughput: one item per cycle while rsp_stall is low; each beat passes an input
//   register, a short chain of add, compare and saturate logic, and the result
//   register, which takes a beat only while it is free or emptying
// reset: synchronous, clears both pipeline valid flags, sets the profile idle at
//   position zero and puts every configuration register at its reset value
module trapezoid_motion_profile_unit
   import tmp_pkg::*;
#(
   parameter int unsigned MAX_STEPS  = MAX_STEPS_DEFAULT,
   parameter int unsigned FORCE_AXES = FORCE_AXES_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_func,
   input  logic signed [POS_W-1:0] req_start_pos,
   input  logic                    req_move_negative,
   input  logic signed [POS_W-1:0] req_force_a,
   input  logic signed [POS_W-1:0] req_force_b,
   input  logic signed [POS_W-1:0] req_force_c,
   input  logic signed [POS_W-1:0] req_force_d,
   input  logic signed [POS_W-1:0] req_force_e,
   input  logic signed [POS_W-1:0] req_force_f,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [POS_W-1:0] rsp_set_point,
   output logic                    rsp_point_valid,
   output logic                    rsp_move_done,
   output logic                    rsp_force_fault,
   output logic                    rsp_step_overrun,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   result_type result, result_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take, advance, force_bad;

   tmp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // handshake: the held beat moves on when the result register is free or emptying
   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign item_valid_in = req_take || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   // input beat capture
   always_comb begin
      item_in               = item_ff;
      if (req_take) begin
         item_in.func          = req_func;
         item_in.start_pos     = req_start_pos;
         item_in.move_negative = req_move_negative;
         item_in.forces        = {req_force_f, req_force_e, req_force_d,
                                  req_force_c, req_force_b, req_force_a};
      end
   end

   tmp_force_check #(
      .FORCE_AXES (FORCE_AXES)
   ) u_force_check (
      .forces         (item_ff.forces),
      .force_limit    (cfg.force_limit),
      .force_check_on (cfg.force_check_on),
      .force_bad      (force_bad)
   );

   tmp_profile_core #(
      .MAX_STEPS (MAX_STEPS)
   ) u_profile_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item_ff),
      .cfg       (cfg),
      .force_bad (force_bad),
      .result    (result)
   );

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_set_point    = result_ff.set_point;
   assign rsp_point_valid  = result_ff.point_valid;
   assign rsp_move_done    = result_ff.move_done;
   assign rsp_force_fault  = result_ff.force_fault;
   assign rsp_step_overrun = result_ff.step_overrun;

endmodule
